### src/group_favoring_lock_queue_macros.svh
// assertion macros shared by the lock queue checker
`ifndef GROUP_FAVORING_LOCK_QUEUE_MACROS_SVH
`define GROUP_FAVORING_LOCK_QUEUE_MACROS_SVH

// generic clocked assertion with active-low reset
`define GFLQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, on the block's own clock and reset names
`define GFLQ_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### src/gflq_pkg.sv
// types, codes and constants of the lock queue
package gflq_pkg;

  localparam int NUM_LOCKS_DEF   = 15;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [6:0]  MOD_DIV   = 7'd100;
  // ceil(2^37 / 100), exact quotient by 100 for any 32-bit draw
  localparam logic [31:0] MOD_RECIP = 32'h51EB_851F;
  localparam int          MOD_SHIFT = 37;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_ACQUIRE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_DESTROY = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  lock_id;
    logic [6:0]  favor_percent;
    logic [15:0] requester_pid;
    logic [7:0]  requester_gid;
    logic [31:0] random_draw;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  created_lock_id;
    logic        handoff_valid;
    logic [15:0] handoff_pid;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  gid;
  } waiter_t;

  typedef struct packed {
    logic cap_item;
    logic exec_op;
    logic idx_inc;
    logic hit_set;
    logic idx_load_tgt;
    logic rd_cur;
    logic rd_next;
    logic wr_cur;
    logic cap_pid;
    logic rel_finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rel_scan;
    logic gid_match;
    logic scan_last;
    logic mod_done;
    logic shift_more;
  } ctrl_sts_t;

endpackage

### src/gflq_ram.sv
// generic single-write, single-read ram with registered read data
module gflq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/gflq_datapath.sv
// slot table, waiter ram, remainder unit and result registers
module gflq_datapath #(
  parameter int NUM_LOCKS   = gflq_pkg::NUM_LOCKS_DEF,
  parameter int QUEUE_DEPTH = gflq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gflq_pkg::in_word_t  in_word_i,
  input  gflq_pkg::ctrl_cmd_t cmd_i,
  output gflq_pkg::ctrl_sts_t sts_o,
  output gflq_pkg::out_word_t out_word_o
);

  localparam int SW    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_LOCKS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int AW1   = AW + 1;
  localparam int EW    = $bits(gflq_pkg::waiter_t);

  gflq_pkg::in_word_t  item_q;
  gflq_pkg::out_word_t res_q, res_d, out_word_q;

  logic [NUM_LOCKS-1:0] slot_active_q, slot_held_q;
  logic [6:0]           slot_favor_q [NUM_LOCKS];
  logic [CW-1:0]        slot_cnt_q   [NUM_LOCKS];

  logic [CW-1:0] idx_q, hit_q;
  logic          hit_found_q;
  logic [26:0]   quot_q;
  logic [6:0]    rem_q;
  logic          mod_busy_q, mod_stage_q;

  logic [SW-1:0] slot, free_idx;
  logic          id_ok, free_found, fav_ok;
  logic          active_sel, held_sel;
  logic [6:0]    favor_sel;
  logic [CW-1:0] cnt_sel, idx_inc;
  logic          grant_now, room, acq_ok, acq_enq;
  logic [AW-1:0] base_addr, wr_addr, rd_addr;
  logic          wr_en, rd_en;
  gflq_pkg::waiter_t wr_data, rd_data;
  logic [63:0]   recip_prod;
  logic [31:0]   quot_back;

  assign slot    = SW'(item_q.lock_id);
  assign id_ok   = (32'(item_q.lock_id) < NUM_LOCKS);
  assign fav_ok  = (item_q.favor_percent <= gflq_pkg::PCT_MAX);
  assign idx_inc = CW'(idx_q + CW'(1));

  always_comb begin
    active_sel = 1'b0;
    held_sel   = 1'b0;
    favor_sel  = '0;
    cnt_sel    = '0;
    if (id_ok) begin
      active_sel = slot_active_q[slot];
      held_sel   = slot_held_q[slot];
      favor_sel  = slot_favor_q[slot];
      cnt_sel    = slot_cnt_q[slot];
    end
  end

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!slot_active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign grant_now = !held_sel && (cnt_sel == '0);
  assign room      = (cnt_sel < CW'(QUEUE_DEPTH));
  assign acq_ok    = id_ok && active_sel;
  assign acq_enq   = (item_q.operation == gflq_pkg::OP_ACQUIRE) && acq_ok && !grant_now && room;

  always_comb begin
    res_d        = '0;
    res_d.status = gflq_pkg::ST_OK;
    case (item_q.operation)
      gflq_pkg::OP_CREATE: begin
        if (!fav_ok || !free_found) begin
          res_d.status = gflq_pkg::ST_ERROR;
        end else begin
          res_d.created_lock_id = 4'(free_idx);
        end
      end
      gflq_pkg::OP_ACQUIRE: begin
        if (!acq_ok) begin
          res_d.status = gflq_pkg::ST_ERROR;
        end else if (grant_now) begin
          res_d.status = gflq_pkg::ST_OK;
        end else if (room) begin
          res_d.status = gflq_pkg::ST_QUEUED;
        end else begin
          res_d.status = gflq_pkg::ST_ERROR;
        end
      end
      default: begin
        if (!id_ok) begin
          res_d.status = gflq_pkg::ST_ERROR;
        end
      end
    endcase
  end

  // slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_active_q <= '0;
      slot_held_q   <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        slot_favor_q[i] <= '0;
        slot_cnt_q[i]   <= '0;
      end
    end else if (cmd_i.exec_op) begin
      case (item_q.operation)
        gflq_pkg::OP_CREATE: begin
          if (fav_ok && free_found) begin
            slot_active_q[free_idx] <= 1'b1;
            slot_favor_q[free_idx]  <= item_q.favor_percent;
          end
        end
        gflq_pkg::OP_ACQUIRE: begin
          if (acq_ok && grant_now) begin
            slot_held_q[slot] <= 1'b1;
          end else if (acq_enq) begin
            slot_cnt_q[slot] <= CW'(cnt_sel + CW'(1));
          end
        end
        gflq_pkg::OP_RELEASE: begin
          if (id_ok) begin
            slot_held_q[slot] <= 1'b0;
          end
        end
        default: begin
          if (id_ok) begin
            slot_active_q[slot] <= 1'b0;
            slot_held_q[slot]   <= 1'b0;
            slot_favor_q[slot]  <= '0;
            slot_cnt_q[slot]    <= '0;
          end
        end
      endcase
    end else if (cmd_i.rel_finish) begin
      slot_held_q[slot] <= 1'b1;
      slot_cnt_q[slot]  <= CW'(cnt_sel - CW'(1));
    end
  end

  // waiter ram, rows of QUEUE_DEPTH entries per slot
  assign base_addr = AW'(AW1'(slot) * AW1'(QUEUE_DEPTH));
  assign wr_en     = (cmd_i.exec_op && acq_enq) || cmd_i.wr_cur;
  assign wr_addr   = base_addr + (cmd_i.wr_cur ? AW'(idx_q) : AW'(cnt_sel));
  assign wr_data   = cmd_i.wr_cur ? rd_data
                                  : gflq_pkg::waiter_t'({item_q.requester_pid,
                                                         item_q.requester_gid});
  assign rd_en     = cmd_i.rd_cur || cmd_i.rd_next;
  assign rd_addr   = base_addr + (cmd_i.rd_next ? AW'(idx_inc) : AW'(idx_q));

  gflq_ram #(
    .Width(EW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // draw mod 100 in two steps: reciprocal quotient, then draw minus quotient times 100
  assign recip_prod = 64'(item_q.random_draw) * 64'(gflq_pkg::MOD_RECIP);
  assign quot_back  = 32'(quot_q) * 32'(gflq_pkg::MOD_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_busy_q  <= 1'b0;
      mod_stage_q <= 1'b0;
    end else if (cmd_i.cap_item) begin
      mod_busy_q  <= 1'b1;
      mod_stage_q <= 1'b0;
    end else if (mod_busy_q) begin
      if (!mod_stage_q) begin
        mod_stage_q <= 1'b1;
      end else begin
        mod_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q <= in_word_i;
    end
    if (mod_busy_q && !mod_stage_q) begin
      quot_q <= 27'(recip_prod >> gflq_pkg::MOD_SHIFT);
    end
    if (mod_busy_q && mod_stage_q) begin
      rem_q <= 7'(item_q.random_draw - quot_back);
    end
  end

  // queue index and favored-waiter tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      hit_q       <= '0;
      hit_found_q <= 1'b0;
    end else if (cmd_i.exec_op) begin
      idx_q       <= '0;
      hit_found_q <= 1'b0;
    end else begin
      if (cmd_i.hit_set) begin
        hit_q       <= idx_q;
        hit_found_q <= 1'b1;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_inc;
      end else if (cmd_i.idx_load_tgt) begin
        idx_q <= (hit_found_q && (rem_q < favor_sel)) ? hit_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_op) begin
      res_q <= res_d;
    end else if (cmd_i.cap_pid) begin
      res_q.handoff_valid <= 1'b1;
      res_q.handoff_pid   <= rd_data.pid;
    end
    if (cmd_i.out_load) begin
      out_word_q <= res_q;
    end
  end

  assign sts_o.rel_scan   = (item_q.operation == gflq_pkg::OP_RELEASE) && id_ok &&
                            (cnt_sel != '0);
  assign sts_o.gid_match  = (rd_data.gid == item_q.requester_gid);
  assign sts_o.scan_last  = (idx_inc == cnt_sel);
  assign sts_o.mod_done   = !mod_busy_q;
  assign sts_o.shift_more = (idx_inc < cnt_sel);
  assign out_word_o       = out_word_q;

endmodule

### src/gflq_ctrl.sv
// sequencer for one operation at a time and the output valid flag
module gflq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  gflq_pkg::ctrl_sts_t sts_i,
  output gflq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_SCAN_RD   = 10'b00_0000_0100,
    S_SCAN_CHK  = 10'b00_0000_1000,
    S_MOD_WAIT  = 10'b00_0001_0000,
    S_TGT_RD    = 10'b00_0010_0000,
    S_TGT_CAP   = 10'b00_0100_0000,
    S_SHIFT_CHK = 10'b00_1000_0000,
    S_SHIFT_WR  = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec_op = 1'b1;
        state_d       = sts_i.rel_scan ? S_SCAN_RD : S_DONE;
      end
      S_SCAN_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.gid_match) begin
          cmd_o.hit_set = 1'b1;
          state_d       = S_MOD_WAIT;
        end else if (sts_i.scan_last) begin
          state_d = S_MOD_WAIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_MOD_WAIT: begin
        if (sts_i.mod_done) begin
          cmd_o.idx_load_tgt = 1'b1;
          state_d            = S_TGT_RD;
        end
      end
      S_TGT_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_TGT_CAP;
      end
      S_TGT_CAP: begin
        cmd_o.cap_pid = 1'b1;
        state_d       = S_SHIFT_CHK;
      end
      S_SHIFT_CHK: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHIFT_WR;
        end else begin
          cmd_o.rel_finish = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_cur  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SHIFT_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### src/group_favoring_lock_queue.sv
// top level of the group-favoring lock queue
// One word in gives one word out. The block takes a word only when it is idle, one
// operation at a time. Create, acquire, destroy, a release with no waiters and any
// rejected call pass from decode straight to the done state, which loads the result register.
// A release with waiters scans the slot's row in the waiter ram one entry at a time,
// a read state then a check state, until it meets the first waiter of the releaser's
// group or the last entry; the draw-mod-100 remainder is a reciprocal multiply and a
// subtraction started right after accept, so it is always ready when the scan ends.
// It then reads the chosen waiter and closes the gap one moved entry at a time.
// The worst case is a release on a full queue with no group match.
// The result register is separate from the sequencer, so a new word is taken while an
// earlier result still waits on a stall; a second finished result then holds the input.
// The waiter ram holds no reset; only entries below a slot's waiter count are read.
module group_favoring_lock_queue #(
  parameter int NUM_LOCKS   = gflq_pkg::NUM_LOCKS_DEF,
  parameter int QUEUE_DEPTH = gflq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gflq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gflq_pkg::out_word_t out_word_o
);

  // command and status between sequencer and datapath
  gflq_pkg::ctrl_cmd_t cmd;
  gflq_pkg::ctrl_sts_t sts;

  gflq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot table, waiter ram, remainder unit, result word
  gflq_datapath #(
    .NUM_LOCKS  (NUM_LOCKS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_word_o(out_word_o)
  );

endmodule

### src/gflq_checker.sv
// port-level checks of the lock queue, bound to the top level
`include "group_favoring_lock_queue_macros.svh"

module gflq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gflq_pkg::out_word_t out_word_o
);

  `GFLQ_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "result word changed while stalled")
  `GFLQ_ASSERT_CLK(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o, "second word taken while busy")
  `GFLQ_ASSERT_CLK(a_status_code, out_valid_o |-> out_word_o.status != 2'd3, "undefined status code")
  `GFLQ_ASSERT(a_handoff_ok, clk_i, rst_ni, out_valid_o && out_word_o.handoff_valid |-> out_word_o.status == gflq_pkg::ST_OK, "handoff without ok status")
  `GFLQ_ASSERT(a_fail_clean, clk_i, rst_ni, out_valid_o && out_word_o.status != gflq_pkg::ST_OK |-> out_word_o.created_lock_id == 4'd0 && !out_word_o.handoff_valid && out_word_o.handoff_pid == 16'd0, "non-ok result carries data")

endmodule

bind group_favoring_lock_queue gflq_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
